// ===== sv/pkfr_pkg.sv =====
// Package for the pointer/keyboard report framer.
// Holds opcodes, device and job codes, the job record and frame helpers.
// Used by every module of the block; depends on nothing.
package pkfr_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_RTS    = 2'd1;
    localparam logic [1:0] OP_DONE   = 2'd2;

    // Device types held in the configuration register.
    localparam logic [2:0] DEV_J = 3'd0;
    localparam logic [2:0] DEV_M = 3'd1;
    localparam logic [2:0] DEV_K = 3'd2;
    localparam logic [2:0] DEV_X = 3'd3;
    localparam logic [2:0] DEV_T = 3'd4;

    // Kinds of transmit job passed from the front to the back.
    localparam logic [1:0] JOB_FRAME    = 2'd0;
    localparam logic [1:0] JOB_ID_FRAME = 2'd1;
    localparam logic [1:0] JOB_FLUSH    = 2'd2;

    // Job queue geometry.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One transmit job: what kind, the id byte, frame length and frame bytes.
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       id;
        logic [2:0]       len;
        logic [3:0][7:0]  bytes;
    } t_job;

    // Push request from the front into the queue.
    typedef struct packed {
        logic  valid;
        t_job  job;
    } t_push;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Id byte sent ahead of the frame on a rising request-to-send.
    function automatic logic [7:0] id_byte(input logic [2:0] dev);
        logic [7:0] b;
        case (dev)
            DEV_M:   b = 8'h4D;
            DEV_K:   b = 8'h4B;
            DEV_X:   b = 8'h58;
            DEV_T:   b = 8'h54;
            default: b = 8'h4A;
        endcase
        return b;
    endfunction

    // Number of frame bytes for a device type.
    function automatic logic [2:0] frame_len(input logic [2:0] dev);
        logic [2:0] n;
        case (dev)
            DEV_K, DEV_X: n = 3'd2;
            DEV_T:        n = 3'd4;
            default:      n = 3'd3;
        endcase
        return n;
    endfunction

    // Saturate a 16-bit signed axis value to signed 8 bits.
    function automatic logic [7:0] sat8(input logic signed [15:0] v);
        logic [7:0] r;
        if (v > 16'sd127) begin
            r = 8'h7F;
        end else if (v < -16'sd128) begin
            r = 8'h80;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/pkfr_front.sv =====
// Front end of the report framer: accepts input beats, builds frames and
// keeps the frame store, pending flag, request-to-send level and device type.
// Depends on pkfr_pkg; pushes transmit jobs into pkfr_queue.
module pkfr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_buttons,
    input  logic signed [15:0] i_x_move,
    input  logic signed [15:0] i_y_move,
    input  logic               i_key_valid,
    input  logic [7:0]         i_key_byte0,
    input  logic [7:0]         i_key_byte1,
    input  logic [7:0]         i_key_byte2,
    input  logic               i_rts_level,
    input  pkfr_pkg::t_q_stat  i_q_stat,
    output pkfr_pkg::t_push    o_push
);
    import pkfr_pkg::*;

    logic [2:0]      r_dev;
    logic [3:0][7:0] r_store;
    logic            r_pending;
    logic            r_rts;

    logic            accept;
    logic [3:0][7:0] frame;
    logic            update;
    logic [7:0]      x_sat;
    logic [7:0]      y_sat;
    t_push           n_push;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    // Build the frame for the configured device type.
    always_comb begin
        x_sat = sat8(i_x_move);
        y_sat = sat8(i_y_move);
        frame = '0;
        unique case (r_dev) inside
            DEV_K, DEV_X: begin
                update   = i_key_valid;
                frame[0] = {1'b1, i_key_byte0[3:0], i_key_byte1[1:0], i_key_byte2[7]};
                frame[1] = {1'b0, i_key_byte2[6:0]};
            end
            DEV_T: begin
                update   = i_key_valid;
                frame[0] = 8'h40;
                frame[1] = {6'b000100, i_key_byte0[3:2]};
                frame[2] = {2'b00, i_key_byte0[1:0], i_key_byte1[1:0], i_key_byte2[7:6]};
                frame[3] = {2'b00, i_key_byte2[5:0]};
            end
            default: begin
                frame[0] = {i_buttons[7:4], y_sat[7:6], x_sat[7:6]};
                frame[1] = {2'b00, x_sat[5:0]};
                frame[2] = {2'b00, y_sat[5:0]};
                update   = (i_x_move != 16'sd0) || (i_y_move != 16'sd0)
                           || (r_store[0] != frame[0]);
            end
        endcase
    end

    // Decide which job, if any, this beat hands to the back end.
    always_comb begin
        n_push           = '0;
        n_push.job.id    = id_byte(r_dev);
        n_push.job.len   = frame_len(r_dev);
        n_push.job.bytes = r_store;
        n_push.job.kind  = JOB_FRAME;
        if (accept) begin
            case (i_opcode)
                OP_REPORT: begin
                    if (!r_pending && update && r_rts) begin
                        n_push.valid     = 1'b1;
                        n_push.job.bytes = frame;
                    end
                end
                OP_RTS: begin
                    if (i_rts_level != r_rts) begin
                        n_push.valid    = 1'b1;
                        n_push.job.kind = i_rts_level ? JOB_ID_FRAME : JOB_FLUSH;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_push = n_push;

    // State updates on accepted beats and configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev     <= DEV_J;
            r_store   <= '0;
            r_pending <= 1'b0;
            r_rts     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dev <= i_cfg_data;
            end
            if (accept) begin
                case (i_opcode)
                    OP_REPORT: begin
                        if (!r_pending && update) begin
                            r_store   <= frame;
                            r_pending <= 1'b1;
                        end
                    end
                    OP_RTS: begin
                        r_rts <= i_rts_level;
                    end
                    OP_DONE: begin
                        r_pending <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sv/pkfr_queue.sv =====
// Short job queue between the framer front and the byte serializer.
// Depends on pkfr_pkg for the job record and the queue depth.
module pkfr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pkfr_pkg::t_push    i_push,
    input  logic               i_pop,
    output pkfr_pkg::t_job     o_head,
    output pkfr_pkg::t_q_stat  o_stat
);
    import pkfr_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    logic            push;
    logic            pop;

    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];
    assign push         = i_push.valid && !o_stat.full;
    assign pop          = i_pop && !o_stat.empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CW'(Q_DEPTH))
        else $error("job queue count above depth");

    // The front never requests a push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_stat.full)
        else $error("push into full job queue");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty job queue");

endmodule

// ===== sv/pkfr_back.sv =====
// Back end of the report framer: walks the job at the queue head and sends
// one byte beat per cycle while i_ready is high, via an output register.
// Depends on pkfr_pkg; pops jobs from pkfr_queue.
module pkfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pkfr_pkg::t_job     i_head,
    input  pkfr_pkg::t_q_stat  i_q_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_flush,
    output logic               o_last_byte
);
    import pkfr_pkg::*;

    logic       r_valid;
    logic [2:0] r_idx;
    logic [7:0] r_byte;
    logic       r_flush;
    logic       r_last;

    logic       load;
    logic       emit;
    logic [2:0] total;
    logic       last;
    logic [2:0] sel_ext;
    logic [7:0] n_byte;

    assign load = !r_valid || i_ready;
    assign emit = load && !i_q_stat.empty;

    // Beat count, position and byte for the job at the head.
    always_comb begin
        case (i_head.kind)
            JOB_FLUSH:    total = 3'd1;
            JOB_ID_FRAME: total = i_head.len + 3'd1;
            default:      total = i_head.len;
        endcase
        last    = (r_idx == total - 3'd1);
        sel_ext = r_idx - {2'b00, (i_head.kind == JOB_ID_FRAME)};
        if (i_head.kind == JOB_FLUSH) begin
            n_byte = 8'h00;
        end else if (i_head.kind == JOB_ID_FRAME && r_idx == 3'd0) begin
            n_byte = i_head.id;
        end else begin
            n_byte = i_head.bytes[sel_ext[1:0]];
        end
    end

    assign o_pop = emit && last;

    // Control: output valid and position within the current job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= emit;
            end
            if (emit) begin
                r_idx <= last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte  <= n_byte;
            r_flush <= (i_head.kind == JOB_FLUSH);
            r_last  <= last;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_flush     = r_flush;
    assign o_last_byte = r_last;

    // A flush beat is always the only and final beat, with a zero byte.
    a_flush_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_flush) |-> (r_last && r_byte == 8'h00))
        else $error("malformed flush beat");

    // The position never runs past the five beats of the longest job.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd4)
        else $error("job position out of range");

    // The position is back at zero after the last beat of a job.
    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 3'd0))
        else $error("job position not reset after last beat");

endmodule

// ===== sv/pointer_keyboard_report_framer_top.sv =====
// Top level of the pointer/keyboard report framer.
// Instantiates pkfr_front, pkfr_queue and pkfr_back; depends on pkfr_pkg.
//
// Turns report, request-to-send and transmit-done beats into serial bytes
// for one link port. The front takes one input beat per cycle as long as
// the two-entry job queue has room; while the queue is full every input
// beat waits, including those that send nothing.
// Each job then leaves the back end at one byte beat per cycle while
// i_ready is high: a report with request-to-send high gives 2 to 4 beats,
// a rising request-to-send gives the id byte plus the frame (3 to 5 beats)
// and a falling one gives a single flush beat. Sustained throughput is set
// by the serializer, one output beat per cycle while i_ready is high. The
// output is registered and the queue holds two jobs, so a waiting result
// blocks new input only once both queue entries are taken. The device type
// register must be written only while idle; the block does not enforce it.
module pointer_keyboard_report_framer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_buttons,
    input  logic signed [15:0] i_x_move,
    input  logic signed [15:0] i_y_move,
    input  logic               i_key_valid,
    input  logic [7:0]         i_key_byte0,
    input  logic [7:0]         i_key_byte1,
    input  logic [7:0]         i_key_byte2,
    input  logic               i_rts_level,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_flush,
    output logic               o_last_byte
);
    import pkfr_pkg::*;

    t_push   push;
    t_job    head;
    t_q_stat q_stat;
    logic    pop;

    // Front: classify beats and build jobs.
    pkfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_buttons   (i_buttons),
        .i_x_move    (i_x_move),
        .i_y_move    (i_y_move),
        .i_key_valid (i_key_valid),
        .i_key_byte0 (i_key_byte0),
        .i_key_byte1 (i_key_byte1),
        .i_key_byte2 (i_key_byte2),
        .i_rts_level (i_rts_level),
        .i_q_stat    (q_stat),
        .o_push      (push)
    );

    // Job queue between the two halves.
    pkfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Back: serialize jobs into byte beats.
    pkfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_flush     (o_flush),
        .o_last_byte (o_last_byte)
    );

endmodule
